[design/mcp_pkg.sv]
`default_nettype none
package mcp_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int OUT_W      = 7;
    localparam int DRAIN_LEN  = 2 * MAX_POINTS + 4;
    localparam int DR_W       = $clog2(DRAIN_LEN + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;

    typedef struct packed {
        logic   v;
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        logic             valid;
        logic             dup;
        coord_t           ax;
        coord_t           ay;
        diff_t            dx;
        diff_t            dy;
        logic [CNT_W-1:0] cnt;
    } token_t;

    typedef struct packed {
        logic shift;
        logic clr;
    } cell_ctl_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] best;
        logic             ovf;
    } result_t;

endpackage
`default_nettype wire

[design/mcp_cell.sv]
`default_nettype none
module mcp_cell
    import mcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  point_t    pt_in,
    output point_t    pt_out,
    input  token_t    tok_in,
    output token_t    tok_out
);

    logic                pt_v_reg;
    coord_t              pt_x_reg;
    coord_t              pt_y_reg;
    token_t              tok1_reg;
    token_t              tok2_reg;
    token_t              tok2_next;
    logic [PROD_W-1:0]   pa_reg;
    logic [PROD_W-1:0]   pb_reg;
    logic                eq_reg;
    diff_t               dx2;
    diff_t               dy2;
    logic                hit;

    assign dx2 = DIFF_W'(pt_x_reg) - DIFF_W'(tok_in.ax);
    assign dy2 = DIFF_W'(pt_y_reg) - DIFF_W'(tok_in.ay);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_v_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            pt_v_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            pt_v_reg <= pt_in.v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            pt_x_reg <= pt_in.x;
            pt_y_reg <= pt_in.y;
        end
        pa_reg <= PROD_W'(signed'(PROD_W'(tok_in.dx)) * signed'(PROD_W'(dy2)));
        pb_reg <= PROD_W'(signed'(PROD_W'(tok_in.dy)) * signed'(PROD_W'(dx2)));
        eq_reg <= (pt_x_reg == tok_in.ax) && (pt_y_reg == tok_in.ay);
    end

    always_comb
    begin
        hit       = tok1_reg.valid && pt_v_reg
                    && (tok1_reg.dup ? eq_reg : (pa_reg == pb_reg));
        tok2_next = tok1_reg;
        tok2_next.cnt = tok1_reg.cnt + CNT_W'(hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg <= '0;
            tok2_reg <= '0;
        end
        else
        begin
            tok1_reg <= tok_in;
            tok2_reg <= tok2_next;
        end
    end

    assign pt_out.v = pt_v_reg;
    assign pt_out.x = pt_x_reg;
    assign pt_out.y = pt_y_reg;
    assign tok_out  = tok2_reg;

endmodule
`default_nettype wire

[design/mcp_seq.sv]
`default_nettype none
module mcp_seq
    import mcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  coord_t    in_x,
    input  coord_t    in_y,
    input  logic      in_has,
    input  logic      in_last,
    output cell_ctl_t ctl,
    output point_t    new_pt,
    output token_t    tok,
    input  token_t    ret,
    input  logic      out_free,
    output result_t   res
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SWEEP = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  n_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  i_next;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  j_next;
    logic [DR_W-1:0]   dr_reg;
    logic [DR_W-1:0]   dr_next;
    logic [CNT_W-1:0]  best_reg;
    logic [CNT_W-1:0]  best_next;
    logic              rd_v_reg;
    logic              rd_dup_reg;
    coord_t            rd_ax_reg;
    coord_t            rd_ay_reg;
    coord_t            rd_bx_reg;
    coord_t            rd_by_reg;
    token_t            tok_reg;
    token_t            tok_next;
    coord_t            mem_x [MAX_POINTS];
    coord_t            mem_y [MAX_POINTS];
    logic              accept;
    logic              store;
    logic              issue;
    logic              j_end;
    logic              i_end;
    logic              send;

    assign accept = in_valid && in_ready;
    assign store  = accept && in_has && (n_reg != CNT_W'(MAX_POINTS));
    assign issue  = (state_reg == S_SWEEP);
    assign j_end  = (CNT_W'(j_reg) == n_reg - 1'b1);
    assign i_end  = (CNT_W'(i_reg) == n_reg - 1'b1);
    assign send   = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        dr_next    = dr_reg;
        best_next  = best_reg;
        if (ret.valid && (ret.cnt > best_reg))
        begin
            best_next = ret.cnt;
        end
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (store)
                    begin
                        n_next = n_reg + 1'b1;
                    end
                    else if (in_has)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        i_next  = '0;
                        j_next  = '0;
                        dr_next = DR_W'(DRAIN_LEN);
                        state_next = (n_next == '0) ? S_DRAIN : S_SWEEP;
                    end
                end
            end
            S_SWEEP:
            begin
                if (j_end)
                begin
                    if (i_end)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (dr_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    dr_next = dr_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    n_next     = '0;
                    ovf_next   = 1'b0;
                    best_next  = '0;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            n_reg      <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            dr_reg     <= '0;
            best_reg   <= '0;
            rd_v_reg   <= 1'b0;
            rd_dup_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            ovf_reg    <= ovf_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            dr_reg     <= dr_next;
            best_reg   <= best_next;
            rd_v_reg   <= issue;
            rd_dup_reg <= (i_reg == j_reg);
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            mem_x[n_reg[IDX_W-1:0]] <= in_x;
            mem_y[n_reg[IDX_W-1:0]] <= in_y;
        end
        rd_ax_reg <= mem_x[i_reg];
        rd_ay_reg <= mem_y[i_reg];
        rd_bx_reg <= mem_x[j_reg];
        rd_by_reg <= mem_y[j_reg];
    end

    always_comb
    begin
        tok_next.valid = rd_v_reg
                         && (rd_dup_reg || (rd_bx_reg != rd_ax_reg)
                             || (rd_by_reg != rd_ay_reg));
        tok_next.dup   = rd_dup_reg;
        tok_next.ax    = rd_ax_reg;
        tok_next.ay    = rd_ay_reg;
        tok_next.dx    = DIFF_W'(rd_bx_reg) - DIFF_W'(rd_ax_reg);
        tok_next.dy    = DIFF_W'(rd_by_reg) - DIFF_W'(rd_ay_reg);
        tok_next.cnt   = '0;
    end

    assign in_ready   = (state_reg == S_LOAD);
    assign ctl.shift  = store;
    assign ctl.clr    = send;
    assign new_pt.v   = 1'b1;
    assign new_pt.x   = in_x;
    assign new_pt.y   = in_y;
    assign tok        = tok_reg;
    assign res.valid  = send;
    assign res.best   = best_reg;
    assign res.ovf    = ovf_reg;

endmodule
`default_nettype wire

[design/max_collinear_points.sv]
// Throughput: one point beat per cycle while loading; a set then sweeps every point pair,
// one pair a cycle, through the row of MAX_POINTS cells (two stages per cell).
// Input is held off from the last beat until the result moves into the output register.
// Reset (rst_n low, asynchronous) empties the store, clears the overflow flag and
// drops any pending result.
`default_nettype none
module max_collinear_points
    import mcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pos_x [15:0], pos_y [31:16]
    input  logic        s_tuser,   // has_point
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // best_count [6:0], overflowed [7]
);

    point_t    pt_w  [MAX_POINTS+1];
    token_t    tok_w [MAX_POINTS+1];
    cell_ctl_t ctl;
    result_t   res;
    logic      out_free;
    logic      m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    mcp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_x     (coord_t'(s_tdata[COORD_BITS-1:0])),
        .in_y     (coord_t'(s_tdata[16+COORD_BITS-1:16])),
        .in_has   (s_tuser),
        .in_last  (s_tlast),
        .ctl      (ctl),
        .new_pt   (pt_w[0]),
        .tok      (tok_w[0]),
        .ret      (tok_w[MAX_POINTS]),
        .out_free (out_free),
        .res      (res)
    );

    for (genvar c = 0; c < MAX_POINTS; c++)
    begin : g_cell
        mcp_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .pt_in   (pt_w[c]),
            .pt_out  (pt_w[c+1]),
            .tok_in  (tok_w[c]),
            .tok_out (tok_w[c+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            m_tdata_reg <= {res.ovf, OUT_W'(res.best)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg ^ {7'd0, pt_w[MAX_POINTS].v & 1'b0};

endmodule
`default_nettype wire

[design/mcp_checker.sv]
`default_nettype none
module mcp_checker
    import mcp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] <= 7'(MAX_POINTS)))
        else $error("best_count above store capacity");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[7]) |-> (m_tdata[6:0] >= 7'd2))
        else $error("full store reported fewer than two points on a line");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input taken straight after the last beat of a set");

    a_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while loading");

endmodule

bind max_collinear_points mcp_checker u_mcp_checker (.*);
`default_nettype wire

[verif/tb_top.sv]
module tb_top;
    import mcp_pkg::*;

    localparam int ITEM_TARGET = 900;
    localparam int RUN_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE      = 2 * MAX_POINTS + 20;

    typedef enum int {SHAPE_WIDE, SHAPE_LINE, SHAPE_GRID} set_shape_t;

    typedef struct packed {
        logic [6:0] best;
        logic       ovf;
    } line_result_t;

    class line_board;
        int           pts_x[$];
        int           pts_y[$];
        bit           dropped;
        line_result_t pending_lines[$];
        int           errors;

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function int longest_line();
            int n;
            int best;
            int dup;
            int cnt;
            n = pts_x.size();
            best = 0;
            for (int i = 0; i < n; i++) begin
                dup = 0;
                for (int k = 0; k < n; k++)
                    if (pts_x[k] == pts_x[i] && pts_y[k] == pts_y[i])
                        dup++;
                if (dup > best)
                    best = dup;
                for (int j = i + 1; j < n; j++) begin
                    if (pts_x[j] == pts_x[i] && pts_y[j] == pts_y[i])
                        continue;
                    cnt = 0;
                    for (int k = 0; k < n; k++)
                        if (longint'(pts_x[j] - pts_x[i]) * longint'(pts_y[k] - pts_y[i]) ==
                            longint'(pts_y[j] - pts_y[i]) * longint'(pts_x[k] - pts_x[i]))
                            cnt++;
                    if (cnt > best)
                        best = cnt;
                end
            end
            return best;
        endfunction

        function void note_beat(coord_t x, coord_t y, bit has_pt, bit is_last);
            line_result_t res;
            if (has_pt) begin
                if (pts_x.size() < MAX_POINTS) begin
                    pts_x.push_back(int'(x));
                    pts_y.push_back(int'(y));
                end else begin
                    dropped = 1'b1;
                end
            end
            if (is_last) begin
                res.best = 7'(longest_line());
                res.ovf  = dropped;
                pending_lines.push_back(res);
                pts_x.delete();
                pts_y.delete();
                dropped = 1'b0;
            end
        endfunction

        task check_result(logic [7:0] beat);
            line_result_t want;
            if (pending_lines.size() == 0) begin
                report($sformatf("result beat 0x%02h with nothing pending", beat));
            end else begin
                want = pending_lines.pop_front();
                if (beat[6:0] !== want.best)
                    report($sformatf("best_count %0d, want %0d", beat[6:0], want.best));
                if (beat[7] !== want.ovf)
                    report($sformatf("overflowed %0b, want %0b", beat[7], want.ovf));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    line_board board = new();
    int        items_sent;
    int        results_seen;
    int        cycle_count;
    logic      hold_off = 1'b0;
    bit        tx_burst;
    bit        rx_burst;

    max_collinear_points u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 19) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 10));
    endfunction

    task automatic send_point(coord_t x, coord_t y, bit has_pt, bit is_last);
        int gap;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= has_pt;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_beat(x, y, has_pt, is_last);
        items_sent++;
    endtask

    task automatic send_set(int n, set_shape_t shape);
        int x0;
        int y0;
        int dx;
        int dy;
        int px;
        int py;
        int step;
        bit tail_point;
        tail_point = (n > 0) && ($urandom_range(0, 1) == 1);
        x0 = int'($urandom_range(0, 64000)) - 32000;
        y0 = int'($urandom_range(0, 64000)) - 32000;
        dx = int'($urandom_range(0, 6)) - 3;
        dy = int'($urandom_range(0, 6)) - 3;
        px = 0;
        py = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_point(coord_t'($urandom), coord_t'($urandom), 1'b0, 1'b0);
            // repeat the previous point now and then to make duplicates
            if (i == 0 || $urandom_range(0, 7) != 0) begin
                case (shape)
                    SHAPE_LINE:
                    begin
                        if ($urandom_range(0, 3) != 0) begin
                            step = int'($urandom_range(0, 40)) - 20;
                            px = x0 + step * dx;
                            py = y0 + step * dy;
                        end else begin
                            px = int'(coord_t'($urandom));
                            py = int'(coord_t'($urandom));
                        end
                    end
                    SHAPE_GRID:
                    begin
                        px = int'($urandom_range(0, 6)) - 3;
                        py = int'($urandom_range(0, 6)) - 3;
                    end
                    default:
                    begin
                        px = int'(coord_t'($urandom));
                        py = int'(coord_t'($urandom));
                    end
                endcase
            end
            send_point(coord_t'(px), coord_t'(py), 1'b1, tail_point && i == n - 1);
        end
        if (!tail_point)
            send_point(coord_t'($urandom), coord_t'($urandom), 1'b0, 1'b1);
    endtask

    // result side: random stalls, plus one long hold-off below
    initial
    begin
        int  rx_wait;
        logic ready_next;
        rx_wait = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready) begin
                board.check_result(m_tdata);
                results_seen++;
                rx_wait = draw_gap(rx_burst);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            ready_next = (rx_wait == 0) && !hold_off;
            if (ready_next != m_tready)
                m_tready <= ready_next;
        end
    end

    // hold off the result side long enough for the input to back up
    initial
    begin
        wait (results_seen >= 6);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int r;
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty set
        send_point(16'sd0, 16'sd0, 1'b0, 1'b1);
        // single point on the last beat
        send_point(16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
        // only duplicates, with an empty marker between them
        send_point(16'sh8000, 16'sh8000, 1'b1, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b1, 1'b0);
        send_point(16'shFFFF, 16'shFFFF, 1'b0, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b1, 1'b1);
        // corners and origin: diagonal through extremes
        send_point(16'sh8000, 16'sh8000, 1'b1, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
        send_point(16'shFFFF, 16'shFFFF, 1'b0, 1'b1);
        // vertical line with a duplicate, last beat carries a point
        send_point(16'sd5, 16'sd100, 1'b1, 1'b0);
        send_point(16'sd5, -16'sd200, 1'b1, 1'b0);
        send_point(16'sd5, 16'sd100, 1'b1, 1'b0);
        send_point(16'sd7, 16'sd100, 1'b1, 1'b0);
        send_point(16'sd5, 16'sh7FFF, 1'b1, 1'b1);

        // full store with points dropped, then a store filled exactly
        send_set(70, SHAPE_GRID);
        send_set(MAX_POINTS, SHAPE_LINE);

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 8);
            else if (r < 6)
                n = $urandom_range(MAX_POINTS - 14, MAX_POINTS);
            else
                n = $urandom_range(0, 12);
            send_set(n, set_shape_t'($urandom_range(0, 2)));
        end
        s_tvalid <= 1'b0;

        while (board.pending_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
